// ===== rtl/hfwrl_pkg.sv =====
package hfwrl_pkg;

	localparam int TableSize  = 256;
	localparam int ProbeLimit = 8;
	localparam int SlotW      = $clog2(TableSize);
	localparam int ProbeW     = $clog2(ProbeLimit + 1);
	localparam int OccW       = $clog2(TableSize + 1);

	localparam logic [1:0] OP_CHECK = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_SWEEP = 2'd2;
	localparam logic [1:0] OP_SPARE = 2'd3;

	localparam logic [3:0] ST_CREATED       = 4'd0;
	localparam logic [3:0] ST_COUNTED       = 4'd1;
	localparam logic [3:0] ST_RESET         = 4'd2;
	localparam logic [3:0] ST_BLOCKED_NOW   = 4'd3;
	localparam logic [3:0] ST_STILL_BLOCKED = 4'd4;
	localparam logic [3:0] ST_NO_SLOT       = 4'd5;
	localparam logic [3:0] ST_DISABLED      = 4'd6;
	localparam logic [3:0] ST_CLEARED       = 4'd7;
	localparam logic [3:0] ST_NOT_FOUND     = 4'd8;
	localparam logic [3:0] ST_SWEPT         = 4'd9;

	localparam logic [0:0] REG_ENABLE = 1'd0;
	localparam logic [0:0] REG_WINDOW = 1'd1;

	typedef struct packed {
		logic [1:0]  op;
		logic [63:0] key_id;
		logic [7:0]  action_code;
		logic [15:0] request_limit;
		logic [31:0] now_seconds;
	} in_item_t;

	typedef struct packed {
		logic        allowed;
		logic [3:0]  status;
		logic [8:0]  removed_count;
		logic [8:0]  occupied_entries;
	} out_item_t;

	typedef struct packed {
		logic [63:0] key;
		logic [7:0]  action;
		logic [15:0] count;
		logic [15:0] limit;
		logic [31:0] win_begin;
		logic [15:0] window_len;
		logic        blocked;
		logic [32:0] block_end;
	} entry_t;

	localparam int EntryW = $bits(entry_t);

endpackage

// ===== rtl/hashed_fixed_window_rate_limiter_unit.sv =====
// Check and clear: one hash step per key byte, then the final mix, and up to
// eight probes, each an address step followed by a registered read. Sweep: one
// entry per cycle. A disabled check or a spare op goes straight to the result.
// One item is in work at a time; the output register lets the next item be taken
// while a result waits. Reset clears valid bits, occupancy, registers (enable 1, window 60).
module hashed_fixed_window_rate_limiter_unit
	import hfwrl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_index,
	input  logic [15:0] cfg_data
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_HASH  = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_EVAL  = 3'd3;
	localparam logic [2:0] S_SWEEP = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	localparam logic [3:0] KeyBytes = 4'd8;

	logic [2:0]        state_q;
	in_item_t          item_q;
	logic              enable_q;
	logic [15:0]       window_q;
	logic [TableSize-1:0] valid_q;
	logic [OccW-1:0]   occ_q;
	logic [31:0]       hash_q;
	logic [3:0]        byte_q;
	logic [SlotW-1:0]  slot_q;
	logic [ProbeW-1:0] probe_q;
	logic [SlotW:0]    sweep_q;
	logic              sweep_rd_q;
	logic [SlotW-1:0]  sweep_slot_q;
	logic [OccW-1:0]   removed_q;
	logic              res_allowed_q;
	logic [3:0]        res_status_q;

	logic              we;
	logic [SlotW-1:0]  waddr;
	entry_t            wdata;
	logic [SlotW-1:0]  raddr;
	entry_t            rdata;

	hfwrl_ram #(.Width(EntryW), .Depth(TableSize)) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// The key is hashed one byte per cycle, most significant byte first.
	logic [7:0] key_byte;
	assign key_byte = item_q.key_id[{3'd7 - byte_q[2:0], 3'b000} +: 8];

	// Final mix: h * 17 * 31 + action, with 527 = 512 + 16 - 1.
	logic [31:0] hash_fin;
	assign hash_fin = ((hash_q << 9) + (hash_q << 4) - hash_q)
		+ {24'd0, item_q.action_code};

	logic        out_free;
	assign out_free  = !out_valid || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	logic        match;
	logic [32:0] wend, sweep_end, now33;
	logic        cur_valid;
	assign now33     = {1'b0, item_q.now_seconds};
	assign cur_valid = valid_q[slot_q];
	assign match     = cur_valid && rdata.key == item_q.key_id
		&& rdata.action == item_q.action_code;
	assign wend      = {1'b0, rdata.win_begin} + {17'd0, rdata.window_len};
	assign sweep_end = {1'b0, rdata.win_begin} + {16'd0, rdata.window_len, 1'b0};

	// Sweep reads entry i and decides it in the next cycle.
	logic sweep_kill;
	assign sweep_kill = sweep_rd_q && valid_q[sweep_slot_q] && now33 > sweep_end;

	always_comb begin
		we    = 1'b0;
		waddr = slot_q;
		wdata = rdata;
		raddr = (state_q == S_SWEEP) ? sweep_q[SlotW-1:0] : slot_q;
		if (state_q == S_EVAL && item_q.op == OP_CHECK) begin
			if (!cur_valid) begin
				we = 1'b1;
				wdata.key           = item_q.key_id;
				wdata.action        = item_q.action_code;
				wdata.count         = 16'd1;
				wdata.limit         = item_q.request_limit;
				wdata.win_begin     = item_q.now_seconds;
				wdata.window_len    = window_q;
				wdata.blocked       = 1'b0;
				wdata.block_end     = '0;
			end else if (match) begin
				priority if (rdata.blocked && rdata.block_end > now33) begin
					we = 1'b0;
				end else if (now33 > wend) begin
					we = 1'b1;
					wdata.count        = 16'd1;
					wdata.win_begin    = item_q.now_seconds;
					wdata.blocked      = 1'b0;
				end else if (rdata.count >= rdata.limit) begin
					we = 1'b1;
					wdata.blocked       = 1'b1;
					wdata.block_end     = now33 + {17'd0, rdata.window_len};
				end else begin
					we = 1'b1;
					wdata.count = rdata.count + 16'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			enable_q   <= 1'b1;
			window_q   <= 16'd60;
			valid_q    <= '0;
			occ_q      <= '0;
			out_valid  <= 1'b0;
			sweep_rd_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_ENABLE: enable_q <= cfg_data[0];
					REG_WINDOW: window_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready && state_q != S_DONE) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						item_q    <= in_data;
						hash_q    <= '0;
						byte_q    <= '0;
						probe_q   <= '0;
						sweep_q   <= '0;
						removed_q <= '0;
						res_allowed_q <= (in_data.op == OP_CHECK) && !enable_q;
						priority if (in_data.op == OP_CHECK && !enable_q) begin
							res_status_q  <= ST_DISABLED;
							state_q       <= S_DONE;
						end else if (in_data.op == OP_SWEEP) begin
							res_status_q <= ST_SWEPT;
							state_q      <= S_SWEEP;
						end else if (in_data.op == OP_CHECK || in_data.op == OP_CLEAR) begin
							state_q <= S_HASH;
						end else begin
							res_status_q <= ST_NOT_FOUND;
							state_q      <= S_DONE;
						end
					end
				end
				S_HASH: begin
					if (byte_q == KeyBytes) begin
						slot_q  <= hash_fin[SlotW-1:0];
						state_q <= S_READ;
					end else begin
						hash_q <= (hash_q << 5) - hash_q + {24'd0, key_byte};
						byte_q <= byte_q + 4'd1;
					end
				end
				S_READ: state_q <= S_EVAL;
				S_EVAL: begin
					if (item_q.op == OP_CHECK) begin
						if (!cur_valid) begin
							valid_q[slot_q] <= 1'b1;
							if (occ_q < OccW'(TableSize)) occ_q <= occ_q + 1'b1;
							res_allowed_q <= 1'b1;
							res_status_q  <= ST_CREATED;
							state_q       <= S_DONE;
						end else if (match) begin
							state_q <= S_DONE;
							priority if (rdata.blocked && rdata.block_end > now33) begin
								res_allowed_q <= 1'b0;
								res_status_q  <= ST_STILL_BLOCKED;
							end else if (now33 > wend) begin
								res_allowed_q <= 1'b1;
								res_status_q  <= ST_RESET;
							end else if (rdata.count >= rdata.limit) begin
								res_allowed_q <= 1'b0;
								res_status_q  <= ST_BLOCKED_NOW;
							end else begin
								res_allowed_q <= 1'b1;
								res_status_q  <= ST_COUNTED;
							end
						end else if (probe_q == ProbeW'(ProbeLimit - 1)) begin
							res_allowed_q <= 1'b1;
							res_status_q  <= ST_NO_SLOT;
							state_q       <= S_DONE;
						end else begin
							probe_q <= probe_q + 1'b1;
							slot_q  <= slot_q + 1'b1;
							state_q <= S_READ;
						end
					end else begin
						if (match) begin
							valid_q[slot_q] <= 1'b0;
							if (occ_q != '0) occ_q <= occ_q - 1'b1;
							res_status_q <= ST_CLEARED;
							state_q      <= S_DONE;
						end else if (probe_q == ProbeW'(ProbeLimit - 1)) begin
							res_status_q <= ST_NOT_FOUND;
							state_q      <= S_DONE;
						end else begin
							probe_q <= probe_q + 1'b1;
							slot_q  <= slot_q + 1'b1;
							state_q <= S_READ;
						end
					end
				end
				S_SWEEP: begin
					sweep_rd_q   <= !sweep_q[SlotW];
					sweep_slot_q <= sweep_q[SlotW-1:0];
					if (!sweep_q[SlotW]) sweep_q <= sweep_q + 1'b1;
					if (sweep_kill) begin
						valid_q[sweep_slot_q] <= 1'b0;
						removed_q <= removed_q + 1'b1;
					end
					if (sweep_q[SlotW] && !sweep_rd_q) begin
						occ_q   <= (occ_q > removed_q) ? occ_q - removed_q : '0;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid                 <= 1'b1;
						out_data.allowed          <= res_allowed_q;
						out_data.status           <= res_status_q;
						out_data.removed_count    <= 9'(removed_q);
						out_data.occupied_entries <= 9'(occ_q);
						state_q                   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OccW'(TableSize))
		else $error("occupancy exceeds table size");
	a_probe_range: assert property (@(posedge clk) disable iff (!arst_n)
		probe_q < ProbeW'(ProbeLimit) || state_q == S_IDLE || state_q == S_SWEEP
		|| state_q == S_DONE || state_q == S_HASH)
		else $error("probe counter overran");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !in_ready)
		else $error("input taken while busy");
	a_write_only_eval: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> state_q == S_EVAL)
		else $error("table written outside evaluation");
`endif

endmodule

// ===== rtl/hfwrl_ram.sv =====
module hfwrl_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== bench/tb.sv =====
module tb;
	import hfwrl_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;

	always #2 clk = ~clk;

	hashed_fixed_window_rate_limiter_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow of the limiter table and its registers.
	logic        lim_enable;
	logic [15:0] lim_window;
	logic        tbl_valid [TableSize];
	entry_t      tbl_entry [TableSize];
	int          tbl_occ;

	out_item_t verdicts[$];
	int errors = 0;
	int idle_cycles = 0;
	bit stim_done = 0;
	bit quiet = 0;
	int hold_off = 0;

	// Keys drawn from a small pool so that entries collide and repeat.
	logic [63:0] key_pool [16];
	logic [7:0]  act_pool [16];

	function automatic int home_of(logic [63:0] key, logic [7:0] act);
		logic [31:0] h;
		h = 0;
		for (int b = 7; b >= 0; b--)
			h = h * 31 + key[8*b +: 8];
		h = h * 17;
		h = h * 31 + act;
		return int'(h % TableSize);
	endfunction

	function automatic bit same_entry(int s, in_item_t it);
		return tbl_valid[s] && tbl_entry[s].key == it.key_id
			&& tbl_entry[s].action == it.action_code;
	endfunction

	function automatic out_item_t limiter_verdict(in_item_t it);
		out_item_t r;
		int s;
		logic [32:0] wend;
		logic [32:0] sweep_end;
		r = '0;
		r.status = ST_NOT_FOUND;
		s = home_of(it.key_id, it.action_code);
		if (it.op == OP_CHECK && !lim_enable) begin
			r.allowed = 1'b1;
			r.status = ST_DISABLED;
		end else if (it.op == OP_CHECK) begin
			r.allowed = 1'b1;
			r.status = ST_NO_SLOT;
			for (int p = 0; p < ProbeLimit; p++) begin
				if (!tbl_valid[s]) begin
					tbl_valid[s] = 1'b1;
					tbl_entry[s] = '{key: it.key_id, action: it.action_code, count: 16'd1,
						limit: it.request_limit, win_begin: it.now_seconds,
						window_len: lim_window, blocked: 1'b0, block_end: '0};
					if (tbl_occ < TableSize) tbl_occ++;
					r.status = ST_CREATED;
					break;
				end
				if (same_entry(s, it)) begin
					wend = {1'b0, tbl_entry[s].win_begin} + tbl_entry[s].window_len;
					if (tbl_entry[s].blocked && tbl_entry[s].block_end > {1'b0, it.now_seconds})
					begin
						r.allowed = 1'b0;
						r.status = ST_STILL_BLOCKED;
					end else if ({1'b0, it.now_seconds} > wend) begin
						tbl_entry[s].count = 16'd1;
						tbl_entry[s].win_begin = it.now_seconds;
						tbl_entry[s].blocked = 1'b0;
						r.status = ST_RESET;
					end else if (tbl_entry[s].count >= tbl_entry[s].limit) begin
						tbl_entry[s].blocked = 1'b1;
						tbl_entry[s].block_end = {1'b0, it.now_seconds}
							+ tbl_entry[s].window_len;
						r.allowed = 1'b0;
						r.status = ST_BLOCKED_NOW;
					end else begin
						tbl_entry[s].count++;
						r.status = ST_COUNTED;
					end
					break;
				end
				s = (s + 1) % TableSize;
			end
		end else if (it.op == OP_CLEAR) begin
			for (int p = 0; p < ProbeLimit; p++) begin
				if (same_entry(s, it)) begin
					tbl_valid[s] = 1'b0;
					tbl_entry[s].count = '0;
					tbl_entry[s].blocked = 1'b0;
					if (tbl_occ > 0) tbl_occ--;
					r.status = ST_CLEARED;
					break;
				end
				s = (s + 1) % TableSize;
			end
		end else if (it.op == OP_SWEEP) begin
			for (int i = 0; i < TableSize; i++) begin
				sweep_end = {1'b0, tbl_entry[i].win_begin}
					+ {tbl_entry[i].window_len, 1'b0};
				if (tbl_valid[i] && {1'b0, it.now_seconds} > sweep_end) begin
					tbl_valid[i] = 1'b0;
					tbl_entry[i].count = '0;
					tbl_entry[i].blocked = 1'b0;
					r.removed_count++;
				end
			end
			tbl_occ = (tbl_occ > r.removed_count) ? tbl_occ - r.removed_count : 0;
			r.status = ST_SWEPT;
		end
		r.occupied_entries = tbl_occ[8:0];
		return r;
	endfunction

	task automatic send_item(in_item_t it);
		in_valid <= 1'b1;
		in_data <= it;
		verdicts.push_back(limiter_verdict(it));
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic gap_maybe();
		int n;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			n = $urandom_range(1, 18);
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (verdicts.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_ENABLE) lim_enable = value[0];
		else lim_window = value;
	endtask

	// Directed rows: op, key, action, limit, now, and a typed-in result where obvious.
	typedef struct {
		in_item_t  item;
		bit        fixed;
		out_item_t want;
	} row_t;

	function automatic in_item_t mk(logic [1:0] op, logic [63:0] k, logic [7:0] a,
		logic [15:0] l, logic [31:0] t);
		in_item_t it;
		it.op = op; it.key_id = k; it.action_code = a; it.request_limit = l;
		it.now_seconds = t;
		return it;
	endfunction

	function automatic in_item_t rand_item();
		in_item_t it;
		int pick;
		pick = $urandom_range(0, 15);
		it.key_id = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : key_pool[pick];
		it.action_code = ($urandom_range(0, 9) == 0) ? 8'($urandom) : act_pool[pick];
		it.request_limit = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
		it.now_seconds = ($urandom_range(0, 19) == 0) ? $urandom
			: 32'hFFFF_FF00 - 32'd300 + $urandom_range(0, 300);
		case ($urandom_range(0, 39))
			0, 1, 2, 3: it.op = OP_CLEAR;
			4: it.op = OP_SWEEP;
			5: it.op = OP_SPARE;
			default: it.op = OP_CHECK;
		endcase
		return it;
	endfunction

	initial begin
		row_t rows[$];
		in_item_t it;
		out_item_t w;
		lim_enable = 1'b1;
		lim_window = 16'd60;
		tbl_occ = 0;
		for (int i = 0; i < TableSize; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_entry[i] = '0;
		end
		for (int i = 0; i < 16; i++) begin
			key_pool[i] = {$urandom, $urandom};
			act_pool[i] = 8'($urandom);
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		w = '0; w.status = ST_NOT_FOUND;
		rows.push_back('{mk(OP_CLEAR, 64'd5, 8'd1, 16'd0, 32'd0), 1, w});
		w = '0; w.status = ST_SWEPT;
		rows.push_back('{mk(OP_SWEEP, '1, '1, '1, '1), 1, w});
		w = '0; w.status = ST_NOT_FOUND;
		rows.push_back('{mk(OP_SPARE, '1, '1, '1, '1), 1, w});
		w = '0; w.allowed = 1'b1; w.status = ST_CREATED; w.occupied_entries = 9'd1;
		rows.push_back('{mk(OP_CHECK, 64'd0, 8'd0, 16'd0, 32'd100), 1, w});
		// Zero limit: the second request in the window blocks.
		rows.push_back('{mk(OP_CHECK, 64'd0, 8'd0, 16'd0, 32'd101), 0, w});
		rows.push_back('{mk(OP_CHECK, 64'd0, 8'd0, 16'd0, 32'd102), 0, w});
		rows.push_back('{mk(OP_CHECK, 64'd0, 8'd0, 16'd0, 32'd200), 0, w});
		rows.push_back('{mk(OP_CHECK, 64'd0, 8'd0, 16'd0, 32'd300), 0, w});
		rows.push_back('{mk(OP_CHECK, '1, '1, '1, '1), 0, w});
		rows.push_back('{mk(OP_CHECK, '1, '1, '1, '1), 0, w});
		rows.push_back('{mk(OP_CHECK, 64'd0, 8'd1, 16'd2, 32'hFFFF_FFF0), 0, w});
		rows.push_back('{mk(OP_CHECK, 64'd0, 8'd1, 16'd2, 32'hFFFF_FFF1), 0, w});
		rows.push_back('{mk(OP_CHECK, 64'd0, 8'd1, 16'd2, 32'hFFFF_FFF2), 0, w});
		rows.push_back('{mk(OP_CHECK, 64'd0, 8'd1, 16'd2, 32'hFFFF_FFFF), 0, w});
		rows.push_back('{mk(OP_CLEAR, '1, '1, 16'd0, 32'd0), 0, w});
		rows.push_back('{mk(OP_CLEAR, '1, '1, 16'd0, 32'd0), 0, w});
		rows.push_back('{mk(OP_SWEEP, 64'd0, 8'd0, 16'd0, 32'd1000), 0, w});
		foreach (rows[i]) begin
			send_item(rows[i].item);
			if (rows[i].fixed) verdicts[verdicts.size()-1] = rows[i].want;
		end
		// Probe chains: same home slot, tables past the probe limit.
		for (int i = 0; i < 10; i++) begin
			it = mk(OP_CHECK, 64'd0, 8'(31 * 0 + i * 0), 16'd3, 32'd500);
			it.key_id = 64'(i) << 8; // overwritten below; the final key gives every item the same home slot
			it.key_id = 64'd0; it.action_code = 8'(i * 0);
			it.key_id = {56'd0, 8'(i)}; it.action_code = 8'd0 - 8'(i * 31 * 17 % 256);
			send_item(it);
		end
		drain();

		// Window zero and disabled limiter, then back.
		write_reg(REG_WINDOW, 16'd0);
		write_reg(REG_ENABLE, 16'd0);
		send_item(mk(OP_CHECK, 64'd7, 8'd7, 16'd1, 32'd5));
		drain();
		write_reg(REG_ENABLE, 16'd1);
		for (int i = 0; i < 4; i++) send_item(mk(OP_CHECK, 64'd7, 8'd7, 16'd1, 32'(5 + i / 2)));
		drain();
		write_reg(REG_WINDOW, 16'hFFFF);

		for (int phase = 0; phase < 5; phase++) begin
			if (phase == 1) begin
				// Receiver stalls long while items keep coming.
				hold_off = 400;
			end
			if (phase == 4) quiet = 1;
			for (int n = 0; n < 240; n++) begin
				send_item(rand_item());
				gap_maybe();
			end
			drain();
			case (phase)
				0: write_reg(REG_WINDOW, 16'd1);
				1: write_reg(REG_WINDOW, 16'd60);
				2: write_reg(REG_ENABLE, 16'd0);
				3: write_reg(REG_ENABLE, 16'd1);
				default: ;
			endcase
		end
		stim_done = 1;
	end

	// Result side: random stalls, plus one long hold-off.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_off > 0) begin
				out_ready <= 1'b0;
				repeat (hold_off) @(posedge clk);
				hold_off = 0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				n = $urandom_range(1, 18);
				repeat (n) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (verdicts.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected transfer %p", out_data);
			end else begin
				if (out_data !== verdicts[0]) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %p actual %p", verdicts[0], out_data);
				end
				void'(verdicts.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (stim_done || idle_cycles >= 20000);
		if (idle_cycles >= 20000) begin
			$display("tb: failure");
		end else if (errors == 0 && verdicts.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
